FILE: hw/rtl/hsirgbw_pkg.sv
// ----------------------------------------------------------------------------
// hsirgbw_pkg
// Shared constants, types and the elaboration-time ratio table builder for
// the HSI to RGBW color converter.
// ----------------------------------------------------------------------------
package hsirgbw_pkg;

  // field widths
  localparam int HUE_W = 12;
  localparam int SAT_W = 10;
  localparam int INT_W = 7;
  localparam int CHAN_W = 8;

  // fraction bits of the sector ratio
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W = RATIO_FRAC_BITS + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

  // hue geometry in tenths of a degree
  localparam int FULL_HUE = 3600;
  localparam int SECTOR_SPAN = 1200;
  localparam int OFF_W = $clog2(SECTOR_SPAN);

  localparam int SAT_FULL = 1000;
  localparam int INT_FULL = 100;
  localparam int CHAN_MAX = 255;

  // intensity times 255, saturation share times that
  localparam int INT255_W = 15;
  localparam int SCALE_W = 25;

  // final division by 1000 * 100 through a reciprocal
  localparam int DIV_DEN = SAT_FULL * INT_FULL;
  localparam int DEN_W = 17;
  localparam int RECIP_SH = 40;
  localparam int RECIP_W = 24;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((64'd1 << RECIP_SH) / DIV_DEN);
  localparam int Q_W = 9;

  typedef enum logic [1:0] {
    SECT_RG = 2'd0,
    SECT_GB = 2'd1,
    SECT_BR = 2'd2
  } sector_t;

  typedef logic [RATIO_W-1:0] ratio_tab_t [SECTOR_SPAN];

  localparam logic [63:0] PI_Q30 = 64'hC90F_DAA2;
  localparam logic [63:0] SQRT3_Q30 = 64'h6ED9_EBA1;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // shift-subtract divide, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] series_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] series_cos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // t = 1/2 - tan(h - 60deg) / (2*sqrt(3)), clamped to [0, 1]
  function automatic ratio_tab_t build_ratio_tab();
    ratio_tab_t tab;
    logic [63:0] one;
    logic [63:0] half;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] sn;
    logic [63:0] cs;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] val;
    logic [63:0] t;
    logic neg;
    one = 64'd1 << RATIO_FRAC_BITS;
    half = one >> 1;
    for (int off = 0; off < SECTOR_SPAN; off++) begin
      neg = off < (SECTOR_SPAN / 2);
      m = neg ? 64'(SECTOR_SPAN / 2 - off) : 64'(off - SECTOR_SPAN / 2);
      x = udiv64(m * PI_Q30, 64'd1800);
      sn = series_sin(x);
      cs = series_cos(x);
      den = (cs * SQRT3_Q30) >> 29;
      num = sn << RATIO_FRAC_BITS;
      val = (den != 64'd0) ? udiv64(num + (den >> 1), den) : 64'd0;
      if (neg) begin
        t = half + val;
        if (t > one) begin
          t = one;
        end
      end else begin
        t = (val >= half) ? 64'd0 : half - val;
      end
      if (off == 0) begin
        t = one;
      end
      tab[OFF_W'(off)] = t[RATIO_W-1:0];
    end
    return tab;
  endfunction

endpackage

FILE: hw/rtl/hsirgbw_if.sv
// ----------------------------------------------------------------------------
// hsirgbw_if
// Valid/ready channels for HSI colors in and RGBW bytes out.
// ----------------------------------------------------------------------------
interface hsirgbw_hsi_if
  import hsirgbw_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [INT_W-1:0] intensity;

  modport source (output valid, output hue, output saturation, output intensity,
                  input ready);
  modport sink (input valid, input hue, input saturation, input intensity,
                output ready);
endinterface

interface hsirgbw_rgbw_if
  import hsirgbw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] white;

  modport source (output valid, output red, output green, output blue, output white,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input white,
                output ready);
endinterface

FILE: hw/rtl/hsi_to_rgbw_color_convert.sv
// ----------------------------------------------------------------------------
// hsi_to_rgbw_color_convert
// Hue/saturation/intensity to red, green, blue and white bytes.
// ----------------------------------------------------------------------------
// Takes one color per clock while the output is not stalled, through a
// five-stage pipeline: hue wrap and clamping, ratio ROM read (1200 entries,
// registered read) with the saturation and intensity products, the ratio
// multiply, a reciprocal multiply for the divide by 100000, and a
// compare-subtract correction with channel steering. Each stage holds its
// own valid bit and moves only when the stage after it is free, so a stall
// on the output leaves items in place and the input keeps accepting until
// the pipeline is full. No reset sweep is needed; the ROM is constant.
module hsi_to_rgbw_color_convert
  import hsirgbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hsirgbw_hsi_if.sink           in_chan,
  hsirgbw_rgbw_if.source        out_chan
);

  localparam ratio_tab_t RATIO_ROM = build_ratio_tab();

  // stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_chan.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_chan.ready = en1;

  // stage 1: wrap, clamp, sector split
  logic [HUE_W-1:0] hue_w;
  sector_t          sect_nxt;
  logic [HUE_W-1:0] off_full;
  logic [SAT_W-1:0] sat_c;
  logic [INT_W-1:0] int_c;

  always_comb begin
    hue_w = (in_chan.hue >= HUE_W'(FULL_HUE)) ? in_chan.hue - HUE_W'(FULL_HUE) : in_chan.hue;
    if (hue_w >= HUE_W'(2 * SECTOR_SPAN)) begin
      sect_nxt = SECT_BR;
      off_full = hue_w - HUE_W'(2 * SECTOR_SPAN);
    end else if (hue_w >= HUE_W'(SECTOR_SPAN)) begin
      sect_nxt = SECT_GB;
      off_full = hue_w - HUE_W'(SECTOR_SPAN);
    end else begin
      sect_nxt = SECT_RG;
      off_full = hue_w;
    end
    sat_c = (in_chan.saturation > SAT_W'(SAT_FULL)) ? SAT_W'(SAT_FULL) : in_chan.saturation;
    int_c = (in_chan.intensity > INT_W'(INT_FULL)) ? INT_W'(INT_FULL) : in_chan.intensity;
  end

  sector_t            sect1_r;
  logic [OFF_W-1:0]   off1_r;
  logic [SAT_W-1:0]   sat1_r;
  logic [INT255_W-1:0] int255_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sect1_r    <= sect_nxt;
      off1_r     <= off_full[OFF_W-1:0];
      sat1_r     <= sat_c;
      int255_1_r <= (INT255_W'(int_c) << 8) - INT255_W'(int_c);
    end
  end

  // stage 2: ratio ROM and the two scale products
  sector_t            sect2_r;
  logic [RATIO_W-1:0] t2_r;
  logic [SCALE_W-1:0] scale2_r;
  logic [SCALE_W-1:0] white2_r;
  logic [SAT_W-1:0]   unsat1;

  assign unsat1 = SAT_W'(SAT_FULL) - sat1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sect2_r  <= sect1_r;
      t2_r     <= RATIO_ROM[off1_r];
      scale2_r <= SCALE_W'(sat1_r) * SCALE_W'(int255_1_r);
      white2_r <= SCALE_W'(unsat1) * SCALE_W'(int255_1_r);
    end
  end

  // stage 3: split the total by the ratio
  localparam int PROD_W = SCALE_W + RATIO_W;

  logic [PROD_W-1:0]  prim_prod;
  logic [PROD_W-1:0]  sec_prod;
  logic [RATIO_W-1:0] t2_inv;

  assign t2_inv    = RATIO_ONE - t2_r;
  assign prim_prod = PROD_W'(scale2_r) * PROD_W'(t2_r);
  assign sec_prod  = PROD_W'(scale2_r) * PROD_W'(t2_inv);

  sector_t            sect3_r;
  logic [SCALE_W-1:0] prim3_r;
  logic [SCALE_W-1:0] sec3_r;
  logic [SCALE_W-1:0] white3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sect3_r  <= sect2_r;
      prim3_r  <= prim_prod[RATIO_FRAC_BITS +: SCALE_W];
      sec3_r   <= sec_prod[RATIO_FRAC_BITS +: SCALE_W];
      white3_r <= white2_r;
    end
  end

  // stage 4: estimate the quotients by 100000, may come out one low
  localparam int RPROD_W = SCALE_W + RECIP_W;

  logic [RPROD_W-1:0] prim_est;
  logic [RPROD_W-1:0] sec_est;
  logic [RPROD_W-1:0] white_est;

  assign prim_est  = RPROD_W'(prim3_r) * RPROD_W'(RECIP_MUL);
  assign sec_est   = RPROD_W'(sec3_r) * RPROD_W'(RECIP_MUL);
  assign white_est = RPROD_W'(white3_r) * RPROD_W'(RECIP_MUL);

  sector_t            sect4_r;
  logic [SCALE_W-1:0] prim4_r, sec4_r, white4_r;
  logic [Q_W-1:0]     qp4_r, qs4_r, qw4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sect4_r  <= sect3_r;
      prim4_r  <= prim3_r;
      sec4_r   <= sec3_r;
      white4_r <= white3_r;
      qp4_r    <= prim_est[RECIP_SH +: Q_W];
      qs4_r    <= sec_est[RECIP_SH +: Q_W];
      qw4_r    <= white_est[RECIP_SH +: Q_W];
    end
  end

  // stage 5: fix the low estimates and steer to the channels
  logic [SCALE_W-1:0] rp, rs, rw;
  logic [Q_W-1:0]     qp, qs, qw;
  logic [CHAN_W-1:0]  red_nxt, green_nxt, blue_nxt;

  always_comb begin
    rp = prim4_r - SCALE_W'(qp4_r) * SCALE_W'(DIV_DEN);
    rs = sec4_r - SCALE_W'(qs4_r) * SCALE_W'(DIV_DEN);
    rw = white4_r - SCALE_W'(qw4_r) * SCALE_W'(DIV_DEN);
    qp = qp4_r + Q_W'(rp >= SCALE_W'(DIV_DEN));
    qs = qs4_r + Q_W'(rs >= SCALE_W'(DIV_DEN));
    qw = qw4_r + Q_W'(rw >= SCALE_W'(DIV_DEN));
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    unique case (sect4_r)
      SECT_RG: begin
        red_nxt   = qp[CHAN_W-1:0];
        green_nxt = qs[CHAN_W-1:0];
      end
      SECT_GB: begin
        green_nxt = qp[CHAN_W-1:0];
        blue_nxt  = qs[CHAN_W-1:0];
      end
      SECT_BR: begin
        blue_nxt  = qp[CHAN_W-1:0];
        red_nxt   = qs[CHAN_W-1:0];
      end
      default: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = '0;
      end
    endcase
  end

  logic [CHAN_W-1:0] red_r, green_r, blue_r, white_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      white_r <= qw[CHAN_W-1:0];
    end
  end

  assign out_chan.valid = v5_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;
  assign out_chan.white = white_r;

endmodule

FILE: test/hsi_to_rgbw_color_convert_chk.sv
// ----------------------------------------------------------------------------
// hsi_to_rgbw_color_convert_chk
// Watches both channels of the color converter, works out the RGBW bytes
// for every accepted HSI color with its own ratio ROM and arithmetic, and
// compares each output transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module hsi_to_rgbw_color_convert_chk
  import hsirgbw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  hsirgbw_hsi_if  in_mon,
  hsirgbw_rgbw_if out_mon,
  output int      fail_count,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;
  } rgbw_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [INT_W-1:0] inten;
    rgbw_t            want;
  } color_entry_t;

  logic [RATIO_W-1:0] ratio_rom [SECTOR_SPAN];
  color_entry_t       rgbw_expected_q [$];

  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    int k;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] cosine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    int k;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    acc = ONE_Q30;
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // t = 1/2 - tan(angle - 60deg) / (2*sqrt(3)), offset 0 pinned to 1.0
  function automatic void fill_ratio_rom();
    logic [63:0] one;
    logic [63:0] half;
    logic [63:0] mid_span;
    logic [63:0] ang;
    logic [63:0] sn;
    logic [63:0] cs;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] t;
    logic        below;
    int          off;
    one = 64'd1 << RATIO_FRAC_BITS;
    half = one >> 1;
    for (off = 0; off < SECTOR_SPAN; off++) begin
      below = off < SECTOR_SPAN / 2;
      mid_span = below ? 64'(SECTOR_SPAN / 2 - off) : 64'(off - SECTOR_SPAN / 2);
      ang = (mid_span * PI_Q30) / 64'd1800;
      sn = sine_q30(ang);
      cs = cosine_q30(ang);
      den = (cs * SQRT3_Q30) >> 29;
      num = sn << RATIO_FRAC_BITS;
      quo = (den != 64'd0) ? (num + den / 64'd2) / den : 64'd0;
      if (below) begin
        t = half + quo;
        if (t > one) begin
          t = one;
        end
      end else begin
        t = (quo >= half) ? 64'd0 : half - quo;
      end
      if (off == 0) begin
        t = one;
      end
      ratio_rom[OFF_W'(off)] = t[RATIO_W-1:0];
    end
  endfunction

  function automatic rgbw_t predict_rgbw(input logic [HUE_W-1:0] hue_in,
                                         input logic [SAT_W-1:0] sat_in,
                                         input logic [INT_W-1:0] int_in);
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] i;
    logic [63:0] t;
    logic [63:0] one;
    logic [63:0] total;
    logic [63:0] prim;
    logic [63:0] second;
    logic [63:0] wht;
    logic [63:0] divisor;
    sector_t     sect;
    rgbw_t       res;
    h = 64'(hue_in);
    s = 64'(sat_in);
    i = 64'(int_in);
    if (h >= 64'(FULL_HUE)) begin
      h = h - 64'(FULL_HUE);
    end
    if (s > 64'(SAT_FULL)) begin
      s = 64'(SAT_FULL);
    end
    if (i > 64'(INT_FULL)) begin
      i = 64'(INT_FULL);
    end
    one = 64'd1 << RATIO_FRAC_BITS;
    sect = sector_t'(2'(h / 64'(SECTOR_SPAN)));
    t = 64'(ratio_rom[OFF_W'(h % 64'(SECTOR_SPAN))]);
    divisor = 64'(SAT_FULL * INT_FULL);
    total = 64'(CHAN_MAX) * s * i;
    prim = (total * t) / (divisor << RATIO_FRAC_BITS);
    second = (total * (one - t)) / (divisor << RATIO_FRAC_BITS);
    wht = (64'(CHAN_MAX) * (64'(SAT_FULL) - s) * i) / divisor;
    res = '0;
    res.white = wht[CHAN_W-1:0];
    case (sect)
      SECT_RG: begin
        res.red = prim[CHAN_W-1:0];
        res.green = second[CHAN_W-1:0];
      end
      SECT_GB: begin
        res.green = prim[CHAN_W-1:0];
        res.blue = second[CHAN_W-1:0];
      end
      default: begin
        res.blue = prim[CHAN_W-1:0];
        res.red = second[CHAN_W-1:0];
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input color_entry_t ent,
                                 input logic [CHAN_W-1:0] got,
                                 input logic [CHAN_W-1:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("%0t: %s mismatch for hue %0d sat %0d int %0d: got %0d, want %0d",
               $realtime, what, ent.hue, ent.sat, ent.inten, got, want);
    end
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    fill_ratio_rom();
  end

  always @(posedge clk) begin
    color_entry_t ent;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        ent.hue = in_mon.hue;
        ent.sat = in_mon.saturation;
        ent.inten = in_mon.intensity;
        ent.want = predict_rgbw(in_mon.hue, in_mon.saturation, in_mon.intensity);
        rgbw_expected_q.push_back(ent);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (rgbw_expected_q.size() == 0) begin
          ent = '{default: '0};
          report_mismatch("unexpected transfer", ent, out_mon.red, '0);
        end else begin
          ent = rgbw_expected_q.pop_front();
          if (out_mon.red !== ent.want.red) begin
            report_mismatch("red", ent, out_mon.red, ent.want.red);
          end
          if (out_mon.green !== ent.want.green) begin
            report_mismatch("green", ent, out_mon.green, ent.want.green);
          end
          if (out_mon.blue !== ent.want.blue) begin
            report_mismatch("blue", ent, out_mon.blue, ent.want.blue);
          end
          if (out_mon.white !== ent.want.white) begin
            report_mismatch("white", ent, out_mon.white, ent.want.white);
          end
        end
      end
      pending <= rgbw_expected_q.size();
    end
  end

endmodule

FILE: test/hsi_to_rgbw_color_convert_tb.sv
// ----------------------------------------------------------------------------
// hsi_to_rgbw_color_convert_tb
// Drives HSI colors into the converter: directed corners first (sector edges,
// hue wrap, saturation and intensity clamps), then random colors in bursts
// while the output side stalls on its own pattern. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hsi_to_rgbw_color_convert_tb
  import hsirgbw_pkg::*;
  ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1080;
  localparam int HOLD_AT = 300;
  localparam int DRAIN_AT = 700;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   stall_cycles;
  int   hold_requests;
  int   holds_done;

  hsirgbw_hsi_if  in_chan ();
  hsirgbw_rgbw_if out_chan ();

  hsi_to_rgbw_color_convert u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hsi_to_rgbw_color_convert_chk u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one color and return at the edge of its transfer
  task automatic send_hsi(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                          input logic [INT_W-1:0] inten);
    in_chan.valid <= 1'b1;
    in_chan.hue <= hue;
    in_chan.saturation <= sat;
    in_chan.intensity <= inten;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // receiver: segments of steady, light, even and heavy stalling, plus long holds
  initial begin
    int seg_kind;
    int seg_len;
    int k;
    logic rdy;
    holds_done = 0;
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      seg_kind = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 40);
      for (k = 0; k < seg_len; k++) begin
        case (seg_kind)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 4) == 0);
        endcase
        out_chan.ready <= rdy;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("hsi_to_rgbw_color_convert_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    int burst_left;
    int gap;
    int pick;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [INT_W-1:0] inten;
    hold_requests = 0;
    stall_cycles = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.hue = '0;
    in_chan.saturation = '0;
    in_chan.intensity = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sector edges, midpoints and hue wrap at full color
    send_hsi(12'd0, 10'd1000, 7'd100);
    send_hsi(12'd1, 10'd1000, 7'd100);
    send_hsi(12'd600, 10'd1000, 7'd100);
    send_hsi(12'd1199, 10'd1000, 7'd100);
    send_hsi(12'd1200, 10'd1000, 7'd100);
    send_hsi(12'd1800, 10'd1000, 7'd100);
    send_hsi(12'd2399, 10'd1000, 7'd100);
    send_hsi(12'd2400, 10'd1000, 7'd100);
    send_hsi(12'd3599, 10'd1000, 7'd100);
    send_hsi(12'd3600, 10'd1000, 7'd100);
    send_hsi(12'd4095, 10'd1000, 7'd100);
    // clamps and all-white / all-dark corners
    send_hsi(12'd300, 10'd0, 7'd100);
    send_hsi(12'd300, 10'd1001, 7'd100);
    send_hsi(12'd300, 10'd1023, 7'd127);
    send_hsi(12'd300, 10'd500, 7'd101);
    send_hsi(12'd300, 10'd500, 7'd0);
    send_hsi(12'd0, 10'd0, 7'd0);
    send_hsi(12'd4095, 10'd1023, 7'd127);
    send_hsi(12'd2000, 10'd999, 7'd1);
    send_hsi(12'd3000, 10'd1, 7'd99);
    send_hsi(12'd2047, 10'd512, 7'd64);

    burst_left = $urandom_range(1, 40);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        // long output hold while colors keep coming, so the pipe fills
        hold_requests++;
        burst_left = 200;
      end
      if (n == DRAIN_AT) begin
        wait_drained();
      end

      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        case ($urandom_range(0, 9))
          0: hue = 12'd0;
          1: hue = 12'd1199;
          2: hue = 12'd1200;
          3: hue = 12'd2399;
          4: hue = 12'd2400;
          5: hue = 12'd3599;
          6: hue = 12'd3600;
          7: hue = 12'd600;
          8: hue = 12'd1800;
          default: hue = 12'd3000;
        endcase
      end else begin
        hue = HUE_W'($urandom_range(0, 4095));
      end

      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        sat = SAT_W'($urandom_range(0, SAT_FULL));
      end else if (pick < 13) begin
        sat = SAT_W'($urandom_range(SAT_FULL + 1, 1023));
      end else if (pick < 16) begin
        sat = ($urandom_range(0, 1) == 0) ? SAT_W'(0) : SAT_W'(SAT_FULL);
      end else begin
        sat = SAT_W'($urandom_range(0, 1023));
      end

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        inten = INT_W'($urandom_range(0, INT_FULL));
      end else if (pick < 8) begin
        inten = INT_W'($urandom_range(INT_FULL + 1, 127));
      end else begin
        inten = ($urandom_range(0, 1) == 0) ? INT_W'(0) : INT_W'(INT_FULL);
      end

      send_hsi(hue, sat, inten);

      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("hsi_to_rgbw_color_convert_tb passed");
    end else begin
      $display("hsi_to_rgbw_color_convert_tb failed");
    end
    $finish;
  end

endmodule
